>>> design/f32vg_pkg.sv
// Shared types and constants for the FAT32 volume geometry block.
`default_nettype none

package f32vg_pkg;

  localparam int unsigned TotalW    = 48;
  localparam int unsigned BpsW      = 16;
  localparam int unsigned DenomW    = 20;
  localparam int unsigned DividendW = TotalW + 1;
  localparam int unsigned DivSteps  = DividendW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);
  localparam int unsigned LgW       = 3;
  localparam int unsigned SpcW      = 7;
  localparam int unsigned Fat32W    = 32;

  localparam logic [TotalW-1:0] ReservedSectors = 48'd32;
  localparam logic [TotalW-1:0] Fat16Limit      = 48'd65524;
  localparam logic [TotalW-1:0] Fat32CountMax   = 48'h0FFF_FFF4;
  localparam logic [BpsW-1:0]   MinSectorBytes  = 16'd512;
  localparam logic [LgW-1:0]    LgMin           = 3'd0;
  localparam logic [LgW-1:0]    LgMax           = 3'd6;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SECT  = 2'd1,
    STATUS_TOO_SMALL = 2'd2,
    STATUS_TOO_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [LgW-1:0] start_lg(input logic [TotalW-1:0] total);
    logic [LgW-1:0] lg;
    if (total <= 48'd532480) begin
      lg = 3'd0;
    end else if (total <= 48'd16777216) begin
      lg = 3'd3;
    end else if (total <= 48'd33554432) begin
      lg = 3'd4;
    end else if (total <= 48'd67108864) begin
      lg = 3'd5;
    end else begin
      lg = 3'd6;
    end
    return lg;
  endfunction

endpackage

`default_nettype wire

>>> design/f32vg_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module f32vg_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [f32vg_pkg::DividendW-1:0]     dividend_i,
  input  wire logic [f32vg_pkg::DenomW-1:0]        divisor_i,
  output f32vg_pkg::div_stat_t                     stat_o,
  output logic [f32vg_pkg::DividendW-1:0]          quotient_o
);

  logic [f32vg_pkg::DividendW-1:0] quo_q, quo_d;
  logic [f32vg_pkg::DenomW-1:0]    rem_q, rem_d;
  logic [f32vg_pkg::DenomW-1:0]    div_q;
  logic [f32vg_pkg::DivCntW-1:0]   cnt_q;
  logic                            busy_q, done_q;
  logic [f32vg_pkg::DenomW:0]      trial;
  logic [f32vg_pkg::DenomW:0]      diff;
  logic                            ge;

  always_comb begin
    trial = {rem_q, quo_q[f32vg_pkg::DividendW-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    rem_d = ge ? diff[f32vg_pkg::DenomW-1:0] : trial[f32vg_pkg::DenomW-1:0];
    quo_d = {quo_q[f32vg_pkg::DividendW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= f32vg_pkg::DivCntW'(f32vg_pkg::DivSteps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == f32vg_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o     = '{busy: busy_q, done: done_q};
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> design/fat32_volume_geometry.sv
// FAT32 volume geometry: top level with trial sequencer and result register.
//
// Takes a volume size and sector size and returns the FAT32 cluster size, table
// size, data cluster count, root directory sector and saturated 32-bit total.
// One item is processed at a time. Each cluster-size trial runs one pass of the
// shared serial divider between a setup state and an evaluation state, with 1 to 6
// trials per item; a rejected sector size skips the divider entirely. The result
// is held in an output register; the next item is taken as soon as the
// sequencer returns to idle, even while that result waits for its transfer.
`default_nettype none

module fat32_volume_geometry (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [47:0]                       total_sectors_i,
  input  wire logic [15:0]                       sector_bytes_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             status_o,
  output logic [6:0]                             sectors_per_cluster_o,
  output logic [31:0]                            fat_size_o,
  output logic [47:0]                            cluster_count_o,
  output logic [47:0]                            root_sector_o,
  output logic [31:0]                            total_sectors_32_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic                            bad_q;
  logic [f32vg_pkg::LgW-1:0]       lg_q;
  logic [f32vg_pkg::TotalW-1:0]    usable_q;
  logic [f32vg_pkg::BpsW-3:0]      bpq_q;
  logic [f32vg_pkg::Fat32W-1:0]    tot32_q;
  logic                            out_valid_q;

  logic [1:0]                      status_q;
  logic [f32vg_pkg::SpcW-1:0]      spc_q;
  logic [f32vg_pkg::Fat32W-1:0]    fat_q;
  logic [f32vg_pkg::TotalW-1:0]    clusters_q;
  logic [f32vg_pkg::TotalW-1:0]    root_q;
  logic [f32vg_pkg::Fat32W-1:0]    tot32_out_q;

  logic                            in_xfer;
  logic                            bad_in;
  logic [f32vg_pkg::BpsW-1:0]      bps_m1;
  logic                            out_free;
  logic                            div_start;
  logic [f32vg_pkg::DenomW-1:0]    denom;
  logic [f32vg_pkg::DividendW-1:0] dividend;
  logic [f32vg_pkg::DividendW-1:0] fat;
  logic [f32vg_pkg::TotalW+1:0]    twice;
  logic [f32vg_pkg::TotalW+1:0]    usable_x;
  logic [f32vg_pkg::TotalW+1:0]    data_x;
  logic [f32vg_pkg::TotalW-1:0]    clusters;
  logic                            trial_ok;
  logic                            trial_last;
  logic                            finish;
  f32vg_pkg::status_e              status_n;
  f32vg_pkg::div_stat_t            div_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    bps_m1 = sector_bytes_i - 1'b1;
    bad_in = (sector_bytes_i < f32vg_pkg::MinSectorBytes) || ((sector_bytes_i & bps_m1) != '0);
  end

  always_comb begin
    denom    = (f32vg_pkg::DenomW'(bpq_q) << lg_q) + f32vg_pkg::DenomW'(2);
    dividend = f32vg_pkg::DividendW'(usable_q) + f32vg_pkg::DividendW'(denom)
             - f32vg_pkg::DividendW'(1);
  end

  assign div_start = (state_q == ST_START);

  f32vg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (denom),
    .stat_o     (div_stat),
    .quotient_o (fat)
  );

  always_comb begin
    twice      = {1'b0, fat};
    twice      = twice << 1;
    usable_x   = {2'b00, usable_q};
    data_x     = (twice > usable_x) ? '0 : (usable_x - twice);
    clusters   = data_x[f32vg_pkg::TotalW-1:0] >> lg_q;
    trial_ok   = clusters > f32vg_pkg::Fat16Limit;
    trial_last = (lg_q == f32vg_pkg::LgMax) || (lg_q == f32vg_pkg::LgMin);
    finish     = bad_q || trial_ok || trial_last;
    if (bad_q) begin
      status_n = f32vg_pkg::STATUS_BAD_SECT;
    end else if (trial_ok) begin
      status_n = (clusters > f32vg_pkg::Fat32CountMax) ? f32vg_pkg::STATUS_TOO_LARGE
                                                       : f32vg_pkg::STATUS_OK;
    end else begin
      status_n = f32vg_pkg::STATUS_TOO_SMALL;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = bad_in ? ST_EVAL : ST_START;
        end
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!finish) begin
          state_d = ST_START;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_EVAL) && finish && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      bad_q    <= bad_in;
      lg_q     <= f32vg_pkg::start_lg(total_sectors_i);
      bpq_q    <= sector_bytes_i[f32vg_pkg::BpsW-1:2];
      usable_q <= (total_sectors_i < f32vg_pkg::ReservedSectors) ? '0
                : (total_sectors_i - f32vg_pkg::ReservedSectors);
      tot32_q  <= (|total_sectors_i[47:32]) ? '1 : total_sectors_i[31:0];
    end else if ((state_q == ST_EVAL) && !finish) begin
      lg_q <= lg_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EVAL) && finish && out_free) begin
      status_q    <= status_n;
      tot32_out_q <= tot32_q;
      if (bad_q) begin
        spc_q      <= '0;
        fat_q      <= '0;
        clusters_q <= '0;
        root_q     <= '0;
      end else begin
        spc_q      <= f32vg_pkg::SpcW'(1) << lg_q;
        fat_q      <= (|fat[f32vg_pkg::DividendW-1:f32vg_pkg::Fat32W]) ? '1
                    : fat[f32vg_pkg::Fat32W-1:0];
        clusters_q <= clusters;
        root_q     <= f32vg_pkg::ReservedSectors + twice[f32vg_pkg::TotalW-1:0];
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign sectors_per_cluster_o = spc_q;
  assign fat_size_o            = fat_q;
  assign cluster_count_o       = clusters_q;
  assign root_sector_o         = root_q;
  assign total_sectors_32_o    = tot32_out_q;

  a_onehot_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_accept_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !div_stat.busy)
    else $error("item taken while divider busy");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside of divide state");

  a_ok_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == f32vg_pkg::STATUS_OK))
      |-> (cluster_count_o > f32vg_pkg::Fat16Limit) && (sectors_per_cluster_o != '0))
    else $error("ok result with too few clusters");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == f32vg_pkg::STATUS_BAD_SECT))
      |-> (sectors_per_cluster_o == '0) && (cluster_count_o == '0))
    else $error("rejected sector size with nonzero geometry");

endmodule

`default_nettype wire
